// ===== rtl/lifegen_pkg.sv =====
// Shared types and constants for the B3/S23 life automaton generation block.
// Used by the column cell, the top level and the port checker; depends on nothing.
package lifegen_pkg;

   localparam int COL_WIDTH   = 6;
   localparam int ROW_WIDTH   = 5;
   localparam int COUNT_WIDTH = 12;
   localparam int COUNT_MAX   = 4095;

   // neighbour counts of the B3/S23 rule
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   typedef enum logic [1:0] {
      FUNC_WRITE  = 2'd0,
      FUNC_TOGGLE = 2'd1,
      FUNC_STEP   = 2'd2,
      FUNC_READ   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_GEN  = 2'd1,
      ST_SUM  = 2'd2
   } state_type;

   // broadcast control from the sequencer to every column cell
   typedef struct packed {
      logic                 gen;
      logic                 first_row;
      logic                 last_row;
      logic                 shift;
      logic                 wr;
      logic                 tgl;
      logic                 value;
      logic [ROW_WIDTH-1:0] row;
   } cell_ctrl_type;

endpackage

// ===== rtl/life_automaton_generation_step.sv =====
// B3/S23 life automaton: a row of COLUMNS column cells, each rotating its column of ROWS bits.
// A cell write, toggle or read answers in the cycle after the transfer; busy stays low.
// Throughput: cell accesses one per cycle while busy is low; a generation keeps busy high for
// a sweep of the rows through the cell chain and then a shift of the column counts out.
// Reset (synchronous, active high) clears the grid to all dead; the receiver cannot stall.
// Depends on lifegen_pkg and lifegen_cell.
module life_automaton_generation_step #(
   parameter int COLUMNS = 64,
   parameter int ROWS    = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_func,
   input  logic [lifegen_pkg::COL_WIDTH-1:0]   req_col,
   input  logic [lifegen_pkg::ROW_WIDTH-1:0]   req_row,
   input  logic                                req_value,
   output logic                                rsp_valid,
   output logic                                rsp_cell_res,
   output logic [lifegen_pkg::COUNT_WIDTH-1:0] rsp_live_count,
   output logic [lifegen_pkg::COUNT_WIDTH-1:0] rsp_dead_count
);

   localparam int CW    = $clog2(ROWS+1);              // per-column live count
   localparam int AW    = $clog2(COLUMNS*ROWS+1);      // whole-grid live count
   localparam int XW    = (AW > lifegen_pkg::COUNT_WIDTH) ? AW : lifegen_pkg::COUNT_WIDTH;
   localparam int RCW   = $clog2(ROWS);
   localparam int SCW   = $clog2(COLUMNS);
   // address compares need room for COLUMNS and ROWS themselves
   localparam int CLW   = $clog2(COLUMNS+1);
   localparam int RLW   = $clog2(ROWS+1);
   localparam int IW    = (CLW > lifegen_pkg::COL_WIDTH) ? CLW : lifegen_pkg::COL_WIDTH;
   localparam int JW    = (RLW > lifegen_pkg::ROW_WIDTH) ? RLW : lifegen_pkg::ROW_WIDTH;

   lifegen_pkg::state_type     state_ff, state_in;
   lifegen_pkg::cell_ctrl_type ctrl;
   lifegen_pkg::func_type      func;

   logic [RCW-1:0] row_cnt_ff, row_cnt_in;
   logic [SCW-1:0] sum_cnt_ff, sum_cnt_in;
   logic [AW-1:0]  acc_ff, acc_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_res_ff, rsp_res_in;
   logic [lifegen_pkg::COUNT_WIDTH-1:0] rsp_live_ff, rsp_live_in;
   logic [lifegen_pkg::COUNT_WIDTH-1:0] rsp_dead_ff, rsp_dead_in;

   logic accept, in_grid, old_bit;
   logic [AW-1:0] acc_sum, dead_sum;
   logic [COLUMNS-1:0] col_sel, rd_bits;
   logic [2:0]    nbr  [COLUMNS];
   logic [CW-1:0] cnt  [COLUMNS];

   assign func    = lifegen_pkg::func_type'(req_func);
   assign accept  = start && (state_ff == lifegen_pkg::ST_IDLE);
   assign in_grid = (IW'(req_col) < IW'(COLUMNS)) && (JW'(req_row) < JW'(ROWS));

   // ---------------------------------------------------------------
   // Column cell chain: neighbours swap their three row bits each cycle,
   // counts drift towards column 0 during the summing pass.
   // ---------------------------------------------------------------
   for (genvar c = 0; c < COLUMNS; c++) begin : g_col
      logic [2:0]    west, east;
      logic [CW-1:0] cin;

      assign col_sel[c] = in_grid && (IW'(req_col) == IW'(c));

      if (c == 0) begin : g_west_edge
         assign west = 3'b000;
      end else begin : g_west
         assign west = nbr[c-1];
      end

      if (c == COLUMNS-1) begin : g_east_edge
         assign east = 3'b000;
         assign cin  = '0;
      end else begin : g_east
         assign east = nbr[c+1];
         assign cin  = cnt[c+1];
      end

      lifegen_cell #(
         .ROWS(ROWS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .col_sel  (col_sel[c]),
         .west_bits(west),
         .east_bits(east),
         .count_in (cin),
         .nbr_bits (nbr[c]),
         .count_out(cnt[c]),
         .rd_bit   (rd_bits[c])
      );
   end

   assign old_bit = |rd_bits;

   // grid totals: live from the accumulator, dead as the remainder
   assign acc_sum  = acc_ff + AW'(cnt[0]);
   assign dead_sum = AW'(COLUMNS*ROWS) - acc_sum;

   // ---------------------------------------------------------------
   // Sequencer: idle / row sweep / count shift-out
   // ---------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      row_cnt_in   = row_cnt_ff;
      sum_cnt_in   = sum_cnt_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_res_in   = 1'b0;
      rsp_live_in  = '0;
      rsp_dead_in  = '0;

      ctrl           = '0;
      ctrl.value     = req_value;
      ctrl.row       = req_row;
      ctrl.first_row = (row_cnt_ff == '0);
      ctrl.last_row  = (row_cnt_ff == RCW'(ROWS-1));

      unique case (state_ff)
         lifegen_pkg::ST_IDLE: begin
            if (accept) begin
               if (func == lifegen_pkg::FUNC_STEP) begin
                  state_in   = lifegen_pkg::ST_GEN;
                  row_cnt_in = '0;
               end else begin
                  // cell access completes in this cycle
                  ctrl.wr      = in_grid && (func == lifegen_pkg::FUNC_WRITE);
                  ctrl.tgl     = in_grid && (func == lifegen_pkg::FUNC_TOGGLE);
                  rsp_valid_in = 1'b1;
                  unique case (func)
                     lifegen_pkg::FUNC_WRITE:  rsp_res_in = in_grid & req_value;
                     lifegen_pkg::FUNC_TOGGLE: rsp_res_in = in_grid & ~old_bit;
                     default:                  rsp_res_in = old_bit;
                  endcase
               end
            end
         end
         lifegen_pkg::ST_GEN: begin
            ctrl.gen   = 1'b1;
            row_cnt_in = row_cnt_ff + RCW'(1);
            if (ctrl.last_row) begin
               state_in   = lifegen_pkg::ST_SUM;
               sum_cnt_in = '0;
               acc_in     = '0;
            end
         end
         lifegen_pkg::ST_SUM: begin
            // take column 0's count and shift the rest one place along
            ctrl.shift = 1'b1;
            acc_in     = acc_sum;
            sum_cnt_in = sum_cnt_ff + SCW'(1);
            if (sum_cnt_ff == SCW'(COLUMNS-1)) begin
               state_in     = lifegen_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_live_in  = (XW'(acc_sum) > XW'(lifegen_pkg::COUNT_MAX))
                            ? lifegen_pkg::COUNT_WIDTH'(lifegen_pkg::COUNT_MAX)
                            : lifegen_pkg::COUNT_WIDTH'(acc_sum);
               rsp_dead_in  = (XW'(dead_sum) > XW'(lifegen_pkg::COUNT_MAX))
                            ? lifegen_pkg::COUNT_WIDTH'(lifegen_pkg::COUNT_MAX)
                            : lifegen_pkg::COUNT_WIDTH'(dead_sum);
            end
         end
         default: begin
            state_in = lifegen_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lifegen_pkg::ST_IDLE;
         row_cnt_ff   <= '0;
         sum_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_cnt_ff   <= row_cnt_in;
         sum_cnt_ff   <= sum_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: hold no reset
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_live_ff <= rsp_live_in;
      rsp_dead_ff <= rsp_dead_in;
   end

   assign busy           = (state_ff != lifegen_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_res   = rsp_res_ff;
   assign rsp_live_count = rsp_live_ff;
   assign rsp_dead_count = rsp_dead_ff;

endmodule

// ===== rtl/lifegen_cell.sv =====
// One column cell of the life automaton: holds a whole grid column as a rotating register.
// Depends on lifegen_pkg for the control struct and rule constants.
module lifegen_cell #(
   parameter int ROWS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lifegen_pkg::cell_ctrl_type ctrl,
   input  logic                      col_sel,
   input  logic [2:0]                west_bits,
   input  logic [2:0]                east_bits,
   input  logic [$clog2(ROWS+1)-1:0] count_in,
   output logic [2:0]                nbr_bits,
   output logic [$clog2(ROWS+1)-1:0] count_out,
   output logic                      rd_bit
);

   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(ROWS+1);

   logic [ROWS-1:0] col_ff, col_in;
   logic            prev_ff, prev_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   logic [RW-1:0] ridx;
   logic          cur, nxt, prv, born;
   logic [3:0]    n;

   assign ridx = RW'(ctrl.row);
   assign cur  = col_ff[0];
   assign nxt  = ctrl.last_row ? 1'b0 : col_ff[1];
   assign prv  = ctrl.first_row ? 1'b0 : prev_ff;

   assign nbr_bits  = {nxt, cur, prv};
   assign count_out = cnt_ff;
   assign rd_bit    = col_sel & col_ff[ridx];

   assign n = 4'(west_bits[0]) + 4'(west_bits[1]) + 4'(west_bits[2])
            + 4'(east_bits[0]) + 4'(east_bits[1]) + 4'(east_bits[2])
            + 4'(prv) + 4'(nxt);

   assign born = (n == lifegen_pkg::BIRTH_COUNT)
               | (cur & (n == lifegen_pkg::SURVIVE_COUNT));

   always_comb begin
      col_in  = col_ff;
      prev_in = prev_ff;
      cnt_in  = cnt_ff;
      if (ctrl.gen) begin
         // write the new row in and rotate the next one to the head
         col_in  = {born, col_ff[ROWS-1:1]};
         prev_in = cur;
         cnt_in  = (ctrl.first_row ? '0 : cnt_ff) + CW'(born);
      end else if (ctrl.shift) begin
         cnt_in = count_in;
      end else if (col_sel && ctrl.wr) begin
         col_in[ridx] = ctrl.value;
      end else if (col_sel && ctrl.tgl) begin
         col_in[ridx] = ~col_ff[ridx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         prev_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         col_ff  <= col_in;
         prev_ff <= prev_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// ===== rtl/lifegen_checker.sv =====
// Port-level checker for the life automaton and its bind to the top level.
// Depends on lifegen_pkg for the function codes.
module lifegen_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic [1:0]                          req_func,
   input logic                                rsp_valid,
   input logic                                rsp_cell_res,
   input logic [lifegen_pkg::COUNT_WIDTH-1:0] rsp_live_count,
   input logic [lifegen_pkg::COUNT_WIDTH-1:0] rsp_dead_count
);

   logic acc_cell, acc_step;

   assign acc_cell = start && !busy && (req_func != lifegen_pkg::FUNC_STEP);
   assign acc_step = start && !busy && (req_func == lifegen_pkg::FUNC_STEP);

   // a cell access answers in the next cycle with zero counts and no busy
   a_cell_answer: assert property (@(posedge clock) disable iff (reset)
      acc_cell |=> rsp_valid && !busy && rsp_live_count == '0 && rsp_dead_count == '0)
      else $error("cell access not answered next cycle");

   // a generation transfer raises busy and gives no immediate answer
   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      acc_step |=> busy && !rsp_valid)
      else $error("generation did not go busy");

   // the end of a generation delivers its counts
   a_step_done: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid && !rsp_cell_res)
      else $error("generation ended without a result");

   // no result appears without a cause
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(acc_cell) || $fell(busy))
      else $error("unexpected result strobe");

endmodule

bind life_automaton_generation_step lifegen_checker u_lifegen_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_func      (req_func),
   .rsp_valid     (rsp_valid),
   .rsp_cell_res  (rsp_cell_res),
   .rsp_live_count(rsp_live_count),
   .rsp_dead_count(rsp_dead_count)
);
